// ----- hw/rtl/signed_number_to_seven_segment_assert.svh -----
// Assertion macros shared by the seven-segment encoder RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef SIGNED_NUMBER_TO_SEVEN_SEGMENT_ASSERT_SVH
`define SIGNED_NUMBER_TO_SEVEN_SEGMENT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define SN7S_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sn7s assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SN7S_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sn7s assertion failed");

// Consequent must hold a fixed number of cycles after the antecedent.
`define SN7S_ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##n (cons)) \
    else $error("sn7s assertion failed");

`else

`define SN7S_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SN7S_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define SN7S_ASSERT_DELAY(label, clk, rst_n, ante, n, cons)

`endif

`endif

// ----- hw/rtl/sn7s_pkg.sv -----
package sn7s_pkg;

  // Display limits.
  localparam int unsigned MaxChars = 4;
  localparam logic signed [15:0] LimitLow  = -16'sd199;
  localparam logic signed [15:0] LimitHigh = 16'sd999;
  localparam logic [7:0] MinusReset = 8'h80;

  // Input item transferred on start.
  typedef struct packed {
    logic signed [15:0] value;
    logic [2:0]         min_digits;
  } item_t;

  // Result item transferred on done.
  typedef struct packed {
    logic [2:0] char_count;
    logic [7:0] char0;
    logic [7:0] char1;
    logic [7:0] char2;
    logic [7:0] char3;
  } result_t;

  // First pipeline stage: range check and magnitude.
  typedef struct packed {
    logic       valid;
    logic       in_range;
    logic       neg;
    logic [9:0] mag;
    logic [2:0] mind;
  } mag_stage_t;

  // Tens-split stage output: decimal digits and digit count.
  typedef struct packed {
    logic       valid;
    logic       in_range;
    logic       neg;
    logic [2:0] ndig;
    logic [3:0] hun;
    logic [3:0] ten;
    logic [3:0] one;
  } digit_stage_t;

  // Segment pattern of one decimal digit; non-decimal codes are blank.
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h7D;
      4'd1:    s = 8'h28;
      4'd2:    s = 8'hDC;
      4'd3:    s = 8'hBC;
      4'd4:    s = 8'hA9;
      4'd5:    s = 8'hB5;
      4'd6:    s = 8'hF5;
      4'd7:    s = 8'h2C;
      4'd8:    s = 8'hFD;
      4'd9:    s = 8'hBD;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/signed_number_to_seven_segment.sv -----
// Signed number to seven-segment character encoder.
//
// Input channel: an item (value, min_digits) transfers on a rising edge with
// start high and busy low. busy is always low, so an item may be offered in
// every cycle.
// Output channel: done_o marks the one cycle in which result_o holds a result;
// the transfer completes at the edge that ends that cycle. The receiver has
// no way to stall, and none is needed since nothing is held back.
// Configuration: cfg_we_i writes cfg_wdata_i into the minus pattern register;
// write it only while no item is in flight.
// Pipeline: an item passes range check, hundreds split, tens split and
// character assembly, each one register stage, before its result transfers.
// Throughput: one item per cycle, set by the four-stage pipeline.
// Reset: clears all stage valid bits, so items in flight are dropped, and
// sets the minus pattern to 0x80.
`include "signed_number_to_seven_segment_assert.svh"

module signed_number_to_seven_segment (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sn7s_pkg::item_t   item_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  output logic              done_o,
  output sn7s_pkg::result_t result_o
);

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Minus pattern register.
  logic [7:0] minus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minus_q <= sn7s_pkg::MinusReset;
    end else if (cfg_we_i) begin
      minus_q <= cfg_wdata_i;
    end
  end

  // Stage one: range check, sign and magnitude, minimum clamp.
  logic              in_range;
  logic [15:0]       mag_w;
  logic [2:0]        mind;
  sn7s_pkg::mag_stage_t s1_q;

  assign in_range = (item_i.value >= sn7s_pkg::LimitLow) &&
                    (item_i.value <= sn7s_pkg::LimitHigh);
  assign mag_w    = item_i.value[15] ? (16'd0 - item_i.value) : item_i.value;
  assign mind     = (item_i.min_digits > 3'(sn7s_pkg::MaxChars)) ?
                    3'(sn7s_pkg::MaxChars) : item_i.min_digits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= '{valid:    start && !busy,
                in_range: in_range,
                neg:      item_i.value[15],
                mag:      mag_w[9:0],
                mind:     mind};
    end
  end

  // Decimal digit split.
  sn7s_pkg::digit_stage_t dig;

  sn7s_bcd u_bcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mag_i  (s1_q),
    .dig_o  (dig)
  );

  // Character assembly and output register.
  sn7s_fmt u_fmt (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dig_i           (dig),
    .minus_pattern_i (minus_q),
    .done_o          (done_o),
    .result_o        (result_o)
  );

  // Every transferred item yields its result after the pipeline latency.
  `SN7S_ASSERT_DELAY(a_latency, clk_i, rst_ni, start && !busy, 4, done_o)
  // An out-of-range result is fully blank.
  `SN7S_ASSERT_IMPLY(a_blank_out_of_range, clk_i, rst_ni,
                     done_o && (result_o.char_count == 3'd0),
                     (result_o.char0 == 8'h00) && (result_o.char1 == 8'h00) &&
                     (result_o.char2 == 8'h00) && (result_o.char3 == 8'h00))
  // Fewer than four characters leaves the last slot empty.
  `SN7S_ASSERT_IMPLY(a_last_slot_unused, clk_i, rst_ni,
                     done_o && (result_o.char_count < 3'd4),
                     result_o.char3 == 8'h00)
  // A configuration write takes effect on the next cycle.
  `SN7S_ASSERT_NEXT(a_cfg_write, clk_i, rst_ni, cfg_we_i, minus_q == $past(cfg_wdata_i))

endmodule

// ----- hw/rtl/sn7s_bcd.sv -----
`include "signed_number_to_seven_segment_assert.svh"

module sn7s_bcd (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sn7s_pkg::mag_stage_t      mag_i,
  output sn7s_pkg::digit_stage_t    dig_o
);

  // Hundreds stage: reciprocal multiply by 41/4096 is exact for values below 1000.
  logic [15:0] hun_prod;
  logic [3:0]  hun;
  logic [10:0] hun_back;
  logic [9:0]  rem_w;
  logic [2:0]  ndig_mag;
  logic [2:0]  ndig;

  assign hun_prod = mag_i.mag * 6'd41;
  assign hun      = hun_prod[15:12];
  assign hun_back = hun * 7'd100;
  assign rem_w    = mag_i.mag - hun_back[9:0];

  // Digits needed by the magnitude, raised to the requested minimum.
  always_comb begin
    if (mag_i.mag > 10'd99) begin
      ndig_mag = 3'd3;
    end else if (mag_i.mag > 10'd9) begin
      ndig_mag = 3'd2;
    end else begin
      ndig_mag = 3'd1;
    end
    ndig = (mag_i.mind > ndig_mag) ? mag_i.mind : ndig_mag;
  end

  logic       s2_valid_q;
  logic       s2_in_range_q;
  logic       s2_neg_q;
  logic [2:0] s2_ndig_q;
  logic [3:0] s2_hun_q;
  logic [6:0] s2_rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= mag_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_in_range_q <= mag_i.in_range;
    s2_neg_q      <= mag_i.neg;
    s2_ndig_q     <= ndig;
    s2_hun_q      <= hun;
    s2_rem_q      <= rem_w[6:0];
  end

  // Tens stage: reciprocal multiply by 103/1024 is exact for values below 100.
  logic [13:0] ten_prod;
  logic [3:0]  ten;
  logic [6:0]  ten_back;
  logic [6:0]  one_w;

  assign ten_prod = s2_rem_q * 7'd103;
  assign ten      = ten_prod[13:10];
  assign ten_back = ten * 4'd10;
  assign one_w    = s2_rem_q - ten_back;

  sn7s_pkg::digit_stage_t s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else begin
      s3_q <= '{valid:    s2_valid_q,
                in_range: s2_in_range_q,
                neg:      s2_neg_q,
                ndig:     s2_ndig_q,
                hun:      s2_hun_q,
                ten:      ten,
                one:      one_w[3:0]};
    end
  end

  assign dig_o = s3_q;

  // The reciprocal splits must leave proper decimal remainders.
  `SN7S_ASSERT_IMPLY(a_rem_below_100, clk_i, rst_ni, s2_valid_q && s2_in_range_q,
                     s2_rem_q < 7'd100)
  `SN7S_ASSERT_IMPLY(a_digits_decimal, clk_i, rst_ni, s3_q.valid && s3_q.in_range,
                     (s3_q.hun < 4'd10) && (s3_q.ten < 4'd10) && (s3_q.one < 4'd10))

endmodule

// ----- hw/rtl/sn7s_fmt.sv -----
module sn7s_fmt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sn7s_pkg::digit_stage_t dig_i,
  input  logic [7:0]             minus_pattern_i,
  output logic                   done_o,
  output sn7s_pkg::result_t      result_o
);

  logic [2:0]  cnt;
  logic [2:0]  off;
  logic [3:0]  digs [4];
  logic [7:0]  chars [4];
  logic [2:0]  pos;
  logic [2:0]  idx;
  sn7s_pkg::result_t result_d;

  // Place the digits right-aligned after an optional leading minus slot.
  always_comb begin
    cnt = (dig_i.neg && (dig_i.ndig < 3'd3)) ? dig_i.ndig + 3'd1 : dig_i.ndig;
    off = cnt - dig_i.ndig;
    digs[0] = dig_i.one;
    digs[1] = dig_i.ten;
    digs[2] = dig_i.hun;
    digs[3] = 4'd0;
    pos = 3'd0;
    idx = 3'd0;
    for (int p = 0; p < sn7s_pkg::MaxChars; p++) begin
      pos = 3'(p);
      idx = cnt - 3'd1 - pos;
      if ((pos < cnt) && (pos >= off)) begin
        chars[p] = sn7s_pkg::seg_of(digs[idx[1:0]]);
      end else begin
        chars[p] = 8'h00;
      end
    end
    if (dig_i.neg) begin
      chars[0] = chars[0] | minus_pattern_i;
    end

    if (dig_i.in_range) begin
      result_d.char_count = cnt;
      result_d.char0      = chars[0];
      result_d.char1      = chars[1];
      result_d.char2      = chars[2];
      result_d.char3      = chars[3];
    end else begin
      result_d = '0;
    end
  end

  // Output register.
  logic              done_q;
  sn7s_pkg::result_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dig_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ----- test/signed_number_to_seven_segment_tb.sv -----
// Keeps the display patterns still owed by the encoder and compares each
// finished transfer against the oldest one.
class seven_segment_scoreboard;
  sn7s_pkg::result_t expected_q[$];
  logic [7:0] minus_bits;
  logic [7:0] digit_seg[10];
  int unsigned errors;

  function new();
    minus_bits = sn7s_pkg::MinusReset;
    digit_seg  = '{8'h7D, 8'h28, 8'hDC, 8'hBC, 8'hA9, 8'hB5, 8'hF5, 8'h2C, 8'hFD, 8'hBD};
    errors     = 0;
  endfunction

  // Works out the characters shown for one number.
  function sn7s_pkg::result_t encode(sn7s_pkg::item_t it);
    sn7s_pkg::result_t res;
    logic [7:0] chars[4];
    int         v;
    int         min_dig;
    int         mag;
    int         digits;
    int         count;
    int         offset;
    bit         neg;

    res     = '0;
    chars   = '{default: 8'h00};
    v       = $signed(it.value);
    min_dig = (it.min_digits > 3'd4) ? 4 : int'(it.min_digits);
    // Numbers the display cannot show give an empty result.
    if (v < -199 || v > 999) begin
      return res;
    end
    neg    = (v < 0);
    mag    = neg ? -v : v;
    digits = 1 + (mag > 9) + (mag > 99);
    if (digits < min_dig) begin
      digits = min_dig;
    end
    // Short negative numbers get a minus character of their own in front.
    count  = (neg && digits < 3) ? digits + 1 : digits;
    offset = count - digits;
    for (int k = digits; k > 0; k--) begin
      chars[k - 1 + offset] = digit_seg[mag % 10];
      mag = mag / 10;
    end
    if (neg) begin
      chars[0] = chars[0] | minus_bits;
    end
    res.char_count = count[2:0];
    res.char0      = chars[0];
    res.char1      = chars[1];
    res.char2      = chars[2];
    res.char3      = chars[3];
    return res;
  endfunction

  function void note_item(sn7s_pkg::item_t it);
    expected_q.push_back(encode(it));
  endfunction

  function void compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%02h, actual 0x%02h", name, exp_val, act_val);
      errors++;
    end
  endfunction

  function void check_result(sn7s_pkg::result_t got);
    sn7s_pkg::result_t exp_res;

    if (expected_q.size() == 0) begin
      $error("result transfer with nothing outstanding: 0x%h", got);
      errors++;
      return;
    end
    exp_res = expected_q.pop_front();
    compare_field("char_count", 8'(exp_res.char_count), 8'(got.char_count));
    compare_field("char0", exp_res.char0, got.char0);
    compare_field("char1", exp_res.char1, got.char1);
    compare_field("char2", exp_res.char2, got.char2);
    compare_field("char3", exp_res.char3, got.char3);
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module signed_number_to_seven_segment_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned ItemsPerPass = 243;
  localparam int unsigned NumPasses    = 7;
  localparam int unsigned DirCount     = 25;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  sn7s_pkg::item_t   item_i;
  logic              cfg_we_i;
  logic [7:0]        cfg_wdata_i;
  logic              done_o;
  sn7s_pkg::result_t result_o;

  seven_segment_scoreboard sb = new();
  int unsigned cycle_count = 0;

  signed_number_to_seven_segment i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  always #5 clk_i = ~clk_i;

  // Watch both channels at every edge and give up on a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("** signed_number_to_seven_segment: FAILED **");
      $finish;
    end
    if (rst_ni) begin
      if (done_o) begin
        sb.check_result(result_o);
      end
      if (start && !busy) begin
        sb.note_item(item_i);
      end
    end
  end

  // Offer one item after an idle gap; start stays high for a back-to-back transfer.
  task automatic send_item(input sn7s_pkg::item_t it, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
  endtask

  // Stop offering items and wait until every outstanding result has arrived.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_minus(input logic [7:0] bits);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= bits;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.minus_bits = bits;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;

    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  initial begin
    int              dir_val[DirCount];
    int              dir_min[DirCount];
    logic [7:0]      minus_plan[NumPasses];
    sn7s_pkg::item_t it;
    int              v;
    bit              quiet;
    int unsigned     sel;

    dir_val    = '{-32768, 32767, -200, 1000, -199, 999, 0, 0, -1, -1,
                   -1, -9, -10, -99, -100, 9, 10, 99, 100, 5,
                   -5, -42, 123, 7, 678};
    dir_min    = '{0, 7, 3, 0, 0, 0, 0, 4, 0, 2,
                   3, 1, 0, 1, 0, 5, 1, 2, 6, 4,
                   4, 3, 4, 7, 3};
    minus_plan = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h00, 8'h00, 8'h00};

    rst_ni      <= 1'b0;
    start       <= 1'b0;
    item_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases under the reset minus pattern.
    for (int i = 0; i < DirCount; i++) begin
      it.value      = dir_val[i][15:0];
      it.min_digits = dir_min[i][2:0];
      send_item(it, (i % 3 == 0) ? 1 : 0);
    end

    // Random passes, each under its own minus pattern written while idle.
    quiet = 1'b0;
    for (int p = 0; p < NumPasses; p++) begin
      drain();
      write_minus((p >= 4) ? 8'($urandom_range(0, 255)) : minus_plan[p]);
      for (int n = 0; n < ItemsPerPass; n++) begin
        if (n % 40 == 0) begin
          quiet = ($urandom_range(0, 3) == 0);
        end
        sel = $urandom_range(0, 9);
        case (sel)
          0, 1:    v = $urandom_range(0, 65535);
          2:       v = $urandom_range(0, 1) ? $urandom_range(0, 3) - 201
                                            : $urandom_range(0, 3) + 997;
          3, 4:    v = $urandom_range(0, 40) - 20;
          default: v = $urandom_range(0, 1198) - 199;
        endcase
        it.value      = v[15:0];
        it.min_digits = 3'($urandom_range(0, 7));
        send_item(it, quiet ? 0 : pick_gap());
      end
    end

    // Let the pipeline empty, then allow a few extra cycles for stray results.
    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** signed_number_to_seven_segment: PASSED **");
    end else begin
      $display("** signed_number_to_seven_segment: FAILED **");
    end
    $finish;
  end
endmodule
